// File: rtl/line_command_prefix_matcher_core_macros.svh
// Assertion macros shared by the matcher RTL.
`ifndef LINE_COMMAND_PREFIX_MATCHER_CORE_MACROS_SVH
`define LINE_COMMAND_PREFIX_MATCHER_CORE_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LCPM_ASSERT_IMPLY(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define LCPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: rtl/lcpm_pkg.sv
`timescale 1ns / 1ps

package lcpm_pkg;

   localparam int LineMaxDefault   = 64;
   localparam int SlotsDefault     = 8;
   localparam int PrefixMaxDefault = 7;

   localparam int ByteWidth    = 8;
   localparam int LenWidth     = 6;
   localparam int SlotIdxWidth = 3;

   localparam int CsrRegs      = 8;
   localparam int CsrDataWidth = 64;
   localparam int CsrAddrWidth = 6;
   localparam int CsrIdxLsb    = 3;
   localparam int CsrIdxWidth  = 3;

   localparam int PlenMsb = 63;
   localparam int PlenLsb = 56;

   localparam logic [ByteWidth-1:0] ChLf = 8'h0A;
   localparam logic [ByteWidth-1:0] ChCr = 8'h0D;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

endpackage

// File: rtl/lcpm_channels_if.sv
`timescale 1ns / 1ps

interface lcpm_req_if;
   logic                             valid;
   logic                             ready;
   logic [lcpm_pkg::ByteWidth-1:0]   rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink (input valid, input rx_byte, output ready);
endinterface

interface lcpm_rsp_if;
   logic                                valid;
   logic                                ready;
   logic                                matched;
   logic [lcpm_pkg::SlotIdxWidth-1:0]   slot_index;
   logic [lcpm_pkg::LenWidth-1:0]       line_length;

   modport source (output valid, output matched, output slot_index, output line_length,
                   input ready);
   modport sink (input valid, input matched, input slot_index, input line_length,
                 output ready);
endinterface

// File: rtl/lcpm_csr.sv
`timescale 1ns / 1ps

module lcpm_csr #(
   parameter int SLOTS = lcpm_pkg::SlotsDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lcpm_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [lcpm_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [lcpm_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready,
   output logic [lcpm_pkg::CsrDataWidth-1:0]    slot_regs [SLOTS]
);

   logic [lcpm_pkg::CsrDataWidth-1:0] slot_ff [SLOTS];
   logic [lcpm_pkg::CsrIdxWidth-1:0]  reg_idx;
   logic                              wr_en;

   assign reg_idx = paddr[lcpm_pkg::CsrIdxLsb +: lcpm_pkg::CsrIdxWidth];
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < SLOTS; s++) begin
            slot_ff[s] <= '0;
         end
      end else if (wr_en) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (int'(reg_idx) == s) begin
               slot_ff[s] <= pwdata;
            end
         end
      end
   end

   always_comb begin
      prdata = '0;
      for (int s = 0; s < SLOTS; s++) begin
         if (int'(reg_idx) == s) begin
            prdata = slot_ff[s];
         end
      end
   end

   assign slot_regs = slot_ff;

endmodule

// File: rtl/lcpm_front.sv
`timescale 1ns / 1ps

module lcpm_front #(
   parameter int LINE_MAX   = lcpm_pkg::LineMaxDefault,
   parameter int PREFIX_MAX = lcpm_pkg::PrefixMaxDefault,
   localparam int CountWidth = $clog2(LINE_MAX),
   localparam int RecWidth   = PREFIX_MAX * lcpm_pkg::ByteWidth + CountWidth
) (
   input  logic                    clock,
   input  logic                    reset,
   lcpm_req_if.sink                req_chan,
   input  lcpm_pkg::q_status_type  q_stat,
   output logic                    push,
   output logic [RecWidth-1:0]     push_rec
);

   localparam logic [CountWidth-1:0] CountLast = CountWidth'(LINE_MAX - 1);

   logic [CountWidth-1:0]          count_ff, count_in;
   logic [lcpm_pkg::ByteWidth-1:0] head_ff [PREFIX_MAX];
   logic                           accept;
   logic                           is_term;

   assign req_chan.ready = ~q_stat.full;
   assign accept         = req_chan.valid & req_chan.ready;
   assign is_term        = (req_chan.rx_byte == lcpm_pkg::ChLf) ||
                           (req_chan.rx_byte == lcpm_pkg::ChCr);

   always_comb begin
      count_in = count_ff;
      push     = 1'b0;
      if (accept) begin
         if (is_term) begin
            push     = (count_ff != '0);
            count_in = '0;
         end else if (count_ff < CountLast) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !is_term) begin
         for (int i = 0; i < PREFIX_MAX; i++) begin
            if (int'(count_ff) == i) begin
               head_ff[i] <= req_chan.rx_byte;
            end
         end
      end
   end

   always_comb begin
      push_rec[RecWidth-1 -: CountWidth] = count_ff;
      for (int i = 0; i < PREFIX_MAX; i++) begin
         push_rec[i*lcpm_pkg::ByteWidth +: lcpm_pkg::ByteWidth] = head_ff[i];
      end
   end

endmodule

// File: rtl/lcpm_queue.sv
`timescale 1ns / 1ps

module lcpm_queue #(
   parameter int WIDTH = 8
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  logic [WIDTH-1:0]        push_rec,
   input  logic                    pop,
   output logic [WIDTH-1:0]        pop_rec,
   output lcpm_pkg::q_status_type  q_stat
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       fill_ff, fill_in;

   assign q_stat.full  = (fill_ff == 2'd2);
   assign q_stat.empty = (fill_ff == 2'd0);
   assign pop_rec      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ pop;
      fill_in   = fill_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         fill_ff   <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_rec;
      end
   end

endmodule

// File: rtl/lcpm_back.sv
`timescale 1ns / 1ps

module lcpm_back #(
   parameter int LINE_MAX   = lcpm_pkg::LineMaxDefault,
   parameter int SLOTS      = lcpm_pkg::SlotsDefault,
   parameter int PREFIX_MAX = lcpm_pkg::PrefixMaxDefault,
   localparam int CountWidth = $clog2(LINE_MAX),
   localparam int RecWidth   = PREFIX_MAX * lcpm_pkg::ByteWidth + CountWidth
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [RecWidth-1:0]                  pop_rec,
   input  lcpm_pkg::q_status_type               q_stat,
   output logic                                 pop,
   input  logic [lcpm_pkg::CsrDataWidth-1:0]    slot_regs [SLOTS],
   lcpm_rsp_if.source                           rsp_chan
);

   localparam logic [2:0] PrefixCap = 3'(PREFIX_MAX);

   logic                               valid_ff, valid_in;
   logic                               matched_ff;
   logic [lcpm_pkg::SlotIdxWidth-1:0]  slot_ff;
   logic [lcpm_pkg::LenWidth-1:0]      len_ff;
   logic [CountWidth-1:0]              rec_count;
   logic [SLOTS-1:0]                   slot_hit;
   logic                               any_hit;
   logic [lcpm_pkg::SlotIdxWidth-1:0]  hit_idx;
   logic [7:0]                         plen;
   logic [2:0]                         eff_len;
   logic                               bytes_ok;

   assign rec_count = pop_rec[RecWidth-1 -: CountWidth];

   always_comb begin
      for (int s = 0; s < SLOTS; s++) begin
         plen    = slot_regs[s][lcpm_pkg::PlenMsb:lcpm_pkg::PlenLsb];
         eff_len = (plen > 8'(PREFIX_MAX)) ? PrefixCap : plen[2:0];
         bytes_ok = 1'b1;
         for (int i = 0; i < PREFIX_MAX; i++) begin
            if (i < int'(eff_len) &&
                pop_rec[i*lcpm_pkg::ByteWidth +: lcpm_pkg::ByteWidth] !=
                slot_regs[s][i*lcpm_pkg::ByteWidth +: lcpm_pkg::ByteWidth]) begin
               bytes_ok = 1'b0;
            end
         end
         slot_hit[s] = (plen != 8'd0) && (rec_count >= CountWidth'(eff_len)) && bytes_ok;
      end
   end

   always_comb begin
      any_hit = |slot_hit;
      hit_idx = '0;
      for (int s = SLOTS - 1; s >= 0; s--) begin
         if (slot_hit[s]) begin
            hit_idx = lcpm_pkg::SlotIdxWidth'(s);
         end
      end
   end

   assign pop      = ~q_stat.empty & (~valid_ff | rsp_chan.ready);
   assign valid_in = pop | (valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         matched_ff <= any_hit;
         slot_ff    <= hit_idx;
         len_ff     <= lcpm_pkg::LenWidth'(rec_count);
      end
   end

   assign rsp_chan.valid       = valid_ff;
   assign rsp_chan.matched     = matched_ff;
   assign rsp_chan.slot_index  = slot_ff;
   assign rsp_chan.line_length = len_ff;

endmodule

// File: rtl/line_command_prefix_matcher_core.sv
`timescale 1ns / 1ps
// Channel    Dir   Handshake               Payload
// req_chan   in    valid/ready             rx_byte
// rsp_chan   out   valid/ready             matched, slot_index, line_length
// APB        in    psel/penable, pready=1  paddr, pwdata, prdata (64-bit slot registers)
//
// One request byte is taken every cycle while the two-entry line queue has room.
// A terminator that closes a non-empty line enters the queue when it is accepted,
// and its response is registered with the slot compare result when the line is popped.
// All SLOTS slot compares (eight by default) run in parallel, combinationally, against the queued line head.
// Reset is synchronous and active high; it clears the line count, queue and slots.
// A stalled response holds in its output register; bytes keep arriving until the queue fills.

`include "line_command_prefix_matcher_core_macros.svh"

module line_command_prefix_matcher_core #(
   parameter int LINE_MAX   = lcpm_pkg::LineMaxDefault,
   parameter int SLOTS      = lcpm_pkg::SlotsDefault,
   parameter int PREFIX_MAX = lcpm_pkg::PrefixMaxDefault
) (
   input  logic                                 clock,
   input  logic                                 reset,
   lcpm_req_if.sink                             req_chan,
   lcpm_rsp_if.source                           rsp_chan,
   input  logic                                 psel,
   input  logic                                 penable,
   input  logic                                 pwrite,
   input  logic [lcpm_pkg::CsrAddrWidth-1:0]    paddr,
   input  logic [lcpm_pkg::CsrDataWidth-1:0]    pwdata,
   output logic [lcpm_pkg::CsrDataWidth-1:0]    prdata,
   output logic                                 pready
);

   localparam int CountWidth = $clog2(LINE_MAX);
   localparam int RecWidth   = PREFIX_MAX * lcpm_pkg::ByteWidth + CountWidth;

   logic [lcpm_pkg::CsrDataWidth-1:0] slot_regs [SLOTS];
   lcpm_pkg::q_status_type            q_stat;
   logic                              push;
   logic                              pop;
   logic [RecWidth-1:0]               push_rec;
   logic [RecWidth-1:0]               pop_rec;

   lcpm_csr #(
      .SLOTS (SLOTS)
   ) u_csr (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .slot_regs (slot_regs)
   );

   lcpm_front #(
      .LINE_MAX   (LINE_MAX),
      .PREFIX_MAX (PREFIX_MAX)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .q_stat   (q_stat),
      .push     (push),
      .push_rec (push_rec)
   );

   lcpm_queue #(
      .WIDTH (RecWidth)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_rec (push_rec),
      .pop      (pop),
      .pop_rec  (pop_rec),
      .q_stat   (q_stat)
   );

   lcpm_back #(
      .LINE_MAX   (LINE_MAX),
      .SLOTS      (SLOTS),
      .PREFIX_MAX (PREFIX_MAX)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_rec   (pop_rec),
      .q_stat    (q_stat),
      .pop       (pop),
      .slot_regs (slot_regs),
      .rsp_chan  (rsp_chan)
   );

   `LCPM_ASSERT_IMPLY(a_queue_state, clock, reset, q_stat.full, !q_stat.empty, "queue full and empty")
   `LCPM_ASSERT_IMPLY(a_push_nonempty, clock, reset, push, push_rec[RecWidth-1 -: CountWidth] != '0, "empty line pushed")
   `LCPM_ASSERT_IMPLY(a_no_push_full, clock, reset, q_stat.full, !push, "push into full queue")
   `LCPM_ASSERT_IMPLY(a_unmatched_index, clock, reset, rsp_chan.valid && !rsp_chan.matched, rsp_chan.slot_index == '0, "unmatched line with nonzero slot")
   `LCPM_ASSERT_NEXT(a_pop_shows, clock, reset, pop, rsp_chan.valid, "popped line not presented")

endmodule
